// File: src/sfq_pkg.sv
`default_nettype none
package sfq_pkg;

	localparam logic [2:0] K_PUSH  = 3'd0;
	localparam logic [2:0] K_POP   = 3'd1;
	localparam logic [2:0] K_DELV  = 3'd2;
	localparam logic [2:0] K_DELP  = 3'd3;
	localparam logic [2:0] K_FIND  = 3'd4;
	localparam logic [2:0] K_READ  = 3'd5;
	localparam logic [2:0] K_CLEAR = 3'd6;
	localparam logic [2:0] K_NOP   = 3'd7;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// address register and read port operations
	localparam logic [2:0] AO_NONE  = 3'd0;
	localparam logic [2:0] AO_POS   = 3'd1;
	localparam logic [2:0] AO_ZERO  = 3'd2;
	localparam logic [2:0] AO_TOP   = 3'd3;
	localparam logic [2:0] AO_DOWN  = 3'd4;
	localparam logic [2:0] AO_NEXT  = 3'd5;
	localparam logic [2:0] AO_SHIFT = 3'd6;

	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;
	localparam logic [1:0] CNT_CLR  = 2'd3;

	localparam logic [1:0] VS_ZERO   = 2'd0;
	localparam logic [1:0] VS_VICTIM = 2'd1;
	localparam logic [1:0] VS_RDDATA = 2'd2;

	localparam logic [1:0] PS_ZERO = 2'd0;
	localparam logic [1:0] PS_BASE = 2'd1;
	localparam logic [1:0] PS_PEND = 2'd2;
	localparam logic [1:0] PS_ADDR = 2'd3;

	typedef struct packed {
		logic       load_op;
		logic [2:0] addr_op;
		logic       victim_load;
		logic       pend_set;
		logic       push_wr;
		logic [1:0] cnt_op;
		logic       emit;
		logic [1:0] em_status;
		logic [1:0] em_val_sel;
		logic [1:0] em_pos_sel;
		logic       em_last;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       out_free;
		logic       empty;
		logic       full;
		logic       pos_oob;
		logic       match;
		logic       addr_zero;
		logic       shift_end;
		logic       pend_v;
	} sts_t;

endpackage
`default_nettype wire

// File: src/searchable_fifo_queue.sv
`default_nettype none
// channel  signals                                             direction
// input    in_valid in_ready kind item_value position          in
// output   out_valid out_ready status result_value
//          result_position entry_count last                    out
//
// one operation at a time; in_ready is high between operations
// push, clear, nop, empty and out-of-range cases answer at dispatch; read waits on memory
// pop, delete at a position and find walk entries one a cycle; a stall can hold find
// delete by value scans down to the match, then shifts newer entries
// arst_n clears the count and out_valid; entries and output data are not cleared
// a stalled output register holds the controller until out_ready

module searchable_fifo_queue #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         kind,
	input  wire logic signed [31:0] item_value,
	input  wire logic [3:0]         position,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [31:0]      result_value,
	output logic [3:0]              result_position,
	output logic [4:0]              entry_count,
	output logic                    last
);
	import sfq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.item_value      (item_value),
		.position        (position),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.result_value    (result_value),
		.result_position (result_position),
		.entry_count     (entry_count),
		.last            (last)
	);

endmodule
`default_nettype wire

// File: src/sfq_ctrl.sv
`default_nettype none
module sfq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire sfq_pkg::sts_t sts,
	output sfq_pkg::cmd_t      cmd
);
	import sfq_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_GRAB  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_FEND  = 3'd5;
	localparam logic [2:0] S_RDOUT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.addr_op = AO_NONE;
		cmd.cnt_op = CNT_HOLD;
		cmd.em_status = ST_OK;
		cmd.em_val_sel = VS_ZERO;
		cmd.em_pos_sel = PS_ZERO;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_op = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				priority if (sts.kind == K_PUSH) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.em_last = 1'b1;
						if (sts.full) begin
							cmd.em_status = ST_FULL;
						end else begin
							cmd.push_wr = 1'b1;
							cmd.cnt_op = CNT_INC;
						end
						state_d = S_IDLE;
					end
				end else if (sts.kind == K_NOP) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.em_last = 1'b1;
						state_d = S_IDLE;
					end
				end else if (sts.empty) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.em_last = 1'b1;
						cmd.em_status = ST_EMPTY;
						state_d = S_IDLE;
					end
				end else begin
					unique case (sts.kind)
						K_POP: begin
							cmd.addr_op = AO_ZERO;
							state_d = S_GRAB;
						end
						K_DELV, K_FIND: begin
							cmd.addr_op = AO_TOP;
							state_d = S_SCAN;
						end
						K_DELP, K_READ: begin
							if (sts.pos_oob) begin
								if (sts.out_free) begin
									cmd.emit = 1'b1;
									cmd.em_last = 1'b1;
									cmd.em_status = ST_NOTFOUND;
									state_d = S_IDLE;
								end
							end else begin
								cmd.addr_op = AO_POS;
								state_d = (sts.kind == K_READ) ? S_RDOUT : S_GRAB;
							end
						end
						K_CLEAR: begin
							if (sts.out_free) begin
								cmd.cnt_op = CNT_CLR;
								cmd.emit = 1'b1;
								cmd.em_last = 1'b1;
								state_d = S_IDLE;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_GRAB: begin
				cmd.victim_load = 1'b1;
				cmd.addr_op = AO_NEXT;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				if (!sts.shift_end) begin
					cmd.addr_op = AO_SHIFT;
				end else if (sts.out_free) begin
					cmd.cnt_op = CNT_DEC;
					cmd.emit = 1'b1;
					cmd.em_last = 1'b1;
					cmd.em_val_sel = VS_VICTIM;
					cmd.em_pos_sel = PS_BASE;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (sts.kind == K_DELV) begin
					priority if (sts.match) begin
						cmd.victim_load = 1'b1;
						cmd.addr_op = AO_NEXT;
						state_d = S_SHIFT;
					end else if (sts.addr_zero) begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.em_last = 1'b1;
							cmd.em_status = ST_NOTFOUND;
							state_d = S_IDLE;
						end
					end else begin
						cmd.addr_op = AO_DOWN;
					end
				end else if (!(sts.match && sts.pend_v && !sts.out_free)) begin
					// earlier-found match goes out once a further (older) match proves it is not the final one
					if (sts.match) begin
						cmd.pend_set = 1'b1;
						if (sts.pend_v) begin
							cmd.emit = 1'b1;
							cmd.em_pos_sel = PS_PEND;
						end
					end
					if (sts.addr_zero) begin
						state_d = S_FEND;
					end else begin
						cmd.addr_op = AO_DOWN;
					end
				end
			end
			S_FEND: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.em_last = 1'b1;
					if (sts.pend_v) begin
						cmd.em_pos_sel = PS_PEND;
					end else begin
						cmd.em_status = ST_NOTFOUND;
					end
					state_d = S_IDLE;
				end
			end
			S_RDOUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.em_last = 1'b1;
					cmd.em_val_sel = VS_RDDATA;
					cmd.em_pos_sel = PS_ADDR;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/sfq_datapath.sv
`default_nettype none
module sfq_datapath #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sfq_pkg::cmd_t      cmd,
	output sfq_pkg::sts_t           sts,
	input  wire logic [2:0]         kind,
	input  wire logic signed [31:0] item_value,
	input  wire logic [3:0]         position,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [31:0]      result_value,
	output logic [3:0]              result_position,
	output logic [4:0]              entry_count,
	output logic                    last
);
	import sfq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = CW + 4;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_data_q;
	logic [AW-1:0]      rd_addr;
	logic               rd_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;
	logic               wr_en;

	logic [2:0]         op_kind_q;
	logic signed [31:0] op_val_q;
	logic [3:0]         op_pos_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      addr_d;
	logic [AW-1:0]      base_q;
	logic signed [31:0] victim_q;
	logic [AW-1:0]      pend_q;
	logic               pend_v_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_next;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic signed [31:0] value_q;
	logic [3:0]         rpos_q;
	logic [4:0]         ecount_q;
	logic               last_q;
	logic signed [31:0] em_val;
	logic [AW-1:0]      em_pos;
	logic [AW-1:0]      top_addr;

	assign top_addr = AW'(count_q - CW'(1));

	always_comb begin
		rd_en = 1'b1;
		rd_addr = addr_q;
		addr_d = addr_q;
		unique case (cmd.addr_op)
			AO_NONE: begin
				rd_en = 1'b0;
			end
			AO_POS: begin
				rd_addr = AW'(op_pos_q);
				addr_d = AW'(op_pos_q);
			end
			AO_ZERO: begin
				rd_addr = '0;
				addr_d = '0;
			end
			AO_TOP: begin
				rd_addr = top_addr;
				addr_d = top_addr;
			end
			AO_DOWN: begin
				rd_addr = addr_q - AW'(1);
				addr_d = addr_q - AW'(1);
			end
			AO_NEXT: begin
				rd_addr = addr_q + AW'(1);
			end
			AO_SHIFT: begin
				rd_addr = addr_q + AW'(2);
				addr_d = addr_q + AW'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// one write port: push at the tail or shift one entry down
	assign wr_en = cmd.push_wr || (cmd.addr_op == AO_SHIFT);
	assign wr_addr = cmd.push_wr ? AW'(count_q) : addr_q;
	assign wr_data = cmd.push_wr ? op_val_q : rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_comb begin
		unique case (cmd.cnt_op)
			CNT_HOLD: count_next = count_q;
			CNT_INC:  count_next = count_q + CW'(1);
			CNT_DEC:  count_next = count_q - CW'(1);
			CNT_CLR:  count_next = '0;
			default:  count_next = count_q;
		endcase
	end

	always_comb begin
		unique case (cmd.em_val_sel)
			VS_VICTIM: em_val = victim_q;
			VS_RDDATA: em_val = rd_data_q;
			default:   em_val = '0;
		endcase
		unique case (cmd.em_pos_sel)
			PS_BASE: em_pos = base_q;
			PS_PEND: em_pos = pend_q;
			PS_ADDR: em_pos = addr_q;
			default: em_pos = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load_op) begin
				pend_v_q <= 1'b0;
			end else if (cmd.pend_set) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			op_kind_q <= kind;
			op_val_q <= item_value;
			op_pos_q <= position;
		end
		addr_q <= addr_d;
		if (cmd.victim_load) begin
			victim_q <= rd_data_q;
			base_q <= addr_q;
		end
		if (cmd.pend_set) begin
			pend_q <= addr_q;
		end
		if (cmd.emit) begin
			status_q <= cmd.em_status;
			value_q <= em_val;
			rpos_q <= 4'(em_pos);
			ecount_q <= 5'(count_next);
			last_q <= cmd.em_last;
		end
	end

	assign sts.kind = op_kind_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.empty = (count_q == '0);
	assign sts.full = (count_q == CW'(DEPTH));
	assign sts.pos_oob = (WW'(op_pos_q) >= WW'(count_q));
	assign sts.match = (rd_data_q == op_val_q);
	assign sts.addr_zero = (addr_q == '0);
	assign sts.shift_end = ((CW'(addr_q) + CW'(1)) >= count_q);
	assign sts.pend_v = pend_v_q;

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign result_value = value_q;
	assign result_position = rpos_q;
	assign entry_count = ecount_q;
	assign last = last_q;

endmodule
`default_nettype wire

// File: test/tb_searchable_fifo_queue.sv
`default_nettype none
module tb_searchable_fifo_queue;
	import sfq_pkg::*;

	localparam int QDEPTH = 16;
	localparam int RANDOM_OPS = 400;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic [3:0]         pos;
		logic [4:0]         count;
		logic               last;
	} queue_result_t;

	typedef struct {
		logic [2:0]         kind;
		logic signed [31:0] value;
		logic [3:0]         pos;
		int                 reps;
		bit                 typed;
		logic [1:0]         t_status;
		logic signed [31:0] t_value;
		logic [4:0]         t_count;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         kind;
	logic signed [31:0] item_value;
	logic [3:0]         position;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [31:0] result_value;
	logic [3:0]         result_position;
	logic [4:0]         entry_count;
	logic               last;

	logic signed [31:0] shadow_entries [$];
	queue_result_t      pending_results [$];
	logic signed [31:0] value_pool [8];
	stim_row_t          dir_rows [30];
	int                 fault_count;
	bit                 calm;

	searchable_fifo_queue #(.DEPTH(QDEPTH)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// expected results of one transaction on the input channel
	function automatic void predict_queue_op(input logic [2:0] op,
			input logic signed [31:0] val, input logic [3:0] pos);
		queue_result_t r;
		int hits;
		r = '{status: ST_OK, value: '0, pos: '0, count: '0, last: 1'b1};
		hits = 0;
		if (op == K_PUSH) begin
			if (shadow_entries.size() >= QDEPTH)
				r.status = ST_FULL;
			else
				shadow_entries.push_back(val);
		end else if (op == K_NOP) begin
			r.status = ST_OK;
		end else if (shadow_entries.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			case (op)
			K_POP: begin
				r.value = shadow_entries.pop_front();
			end
			K_DELV: begin
				r.status = ST_NOTFOUND;
				for (int i = shadow_entries.size() - 1; i >= 0; i--) begin
					if (r.status == ST_NOTFOUND && shadow_entries[i] == val) begin
						r.status = ST_OK;
						r.value = shadow_entries[i];
						r.pos = 4'(i);
						shadow_entries.delete(i);
					end
				end
			end
			K_DELP: begin
				if (pos >= shadow_entries.size()) begin
					r.status = ST_NOTFOUND;
				end else begin
					r.value = shadow_entries[pos];
					r.pos = pos;
					shadow_entries.delete(pos);
				end
			end
			K_FIND: begin
				r.count = 5'(shadow_entries.size());
				r.last = 1'b0;
				for (int i = shadow_entries.size() - 1; i >= 0; i--) begin
					if (shadow_entries[i] == val) begin
						r.pos = 4'(i);
						pending_results.push_back(r);
						hits++;
					end
				end
				if (hits != 0) begin
					pending_results[$].last = 1'b1;
					return;
				end
				r = '{status: ST_NOTFOUND, value: '0, pos: '0, count: '0, last: 1'b1};
			end
			K_READ: begin
				if (pos >= shadow_entries.size()) begin
					r.status = ST_NOTFOUND;
				end else begin
					r.value = shadow_entries[pos];
					r.pos = pos;
				end
			end
			default: begin
				shadow_entries.delete();
			end
			endcase
		end
		r.count = 5'(shadow_entries.size());
		pending_results.push_back(r);
	endfunction

	task automatic send_op(input logic [2:0] op, input logic signed [31:0] val,
			input logic [3:0] pos, input bit typed, input queue_result_t typed_res);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		item_value <= val;
		position <= pos;
		do @(negedge clk); while (!in_ready);
		predict_queue_op(op, val, pos);
		if (typed)
			pending_results[$] = typed_res;
		@(posedge clk);
	endtask

	initial begin : result_side
		int stall;
		queue_result_t got;
		queue_result_t want;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
			got = '{status: status, value: result_value, pos: result_position,
				count: entry_count, last: last};
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("unexpected transaction: st=%0d val=%0d pos=%0d cnt=%0d last=%0d",
						got.status, got.value, got.pos, got.count, got.last);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.value !== want.value ||
						got.pos !== want.pos || got.count !== want.count ||
						got.last !== want.last) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("mismatch: exp st=%0d val=%0d pos=%0d cnt=%0d last=%0d, got st=%0d val=%0d pos=%0d cnt=%0d last=%0d",
							want.status, want.value, want.pos, want.count, want.last,
							got.status, got.value, got.pos, got.count, got.last);
				end
			end
			@(posedge clk);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("FAIL searchable_fifo_queue");
		$finish;
	end

	initial begin : op_side
		queue_result_t typed_res;
		logic [2:0] op;
		logic signed [31:0] val;
		logic [3:0] pos;
		int push_pct;
		int pick;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= K_NOP;
		item_value <= '0;
		position <= '0;
		fault_count = 0;
		calm = 1'b0;
		value_pool[0] = 32'sh80000000;
		value_pool[1] = 32'sh7fffffff;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;
		dir_rows = '{
			'{K_POP,   32'sd0,          4'd0,  1,  1'b1, ST_EMPTY,    32'sd0, 5'd0},
			'{K_CLEAR, 32'sd0,          4'd0,  1,  1'b1, ST_EMPTY,    32'sd0, 5'd0},
			'{K_FIND,  32'sd0,          4'd0,  1,  1'b1, ST_EMPTY,    32'sd0, 5'd0},
			'{K_READ,  32'sd0,          4'd0,  1,  1'b1, ST_EMPTY,    32'sd0, 5'd0},
			'{K_DELP,  32'sd0,          4'd0,  1,  1'b1, ST_EMPTY,    32'sd0, 5'd0},
			'{K_DELV,  32'sd0,          4'd0,  1,  1'b1, ST_EMPTY,    32'sd0, 5'd0},
			'{K_NOP,   32'sd0,          4'd0,  1,  1'b1, ST_OK,       32'sd0, 5'd0},
			'{K_PUSH,  32'sh80000000,   4'd0,  1,  1'b1, ST_OK,       32'sd0, 5'd1},
			'{K_PUSH,  32'sh7fffffff,   4'd0,  1,  1'b1, ST_OK,       32'sd0, 5'd2},
			'{K_PUSH,  32'sh5a5a5a5a,   4'd0,  1,  1'b1, ST_OK,       32'sd0, 5'd3},
			'{K_PUSH,  32'sh80000000,   4'd0,  1,  1'b1, ST_OK,       32'sd0, 5'd4},
			'{K_PUSH,  -32'sd1,         4'd0,  1,  1'b1, ST_OK,       32'sd0, 5'd5},
			'{K_FIND,  32'sh80000000,   4'd0,  1,  1'b0, ST_OK,       32'sd0, 5'd0},
			'{K_FIND,  32'sd12345,      4'd0,  1,  1'b1, ST_NOTFOUND, 32'sd0, 5'd5},
			'{K_READ,  32'sd0,          4'd15, 1,  1'b1, ST_NOTFOUND, 32'sd0, 5'd5},
			'{K_READ,  32'sd0,          4'd4,  1,  1'b0, ST_OK,       32'sd0, 5'd0},
			'{K_DELP,  32'sd0,          4'd15, 1,  1'b1, ST_NOTFOUND, 32'sd0, 5'd5},
			'{K_DELV,  32'sd777,        4'd0,  1,  1'b1, ST_NOTFOUND, 32'sd0, 5'd5},
			'{K_DELV,  32'sh80000000,   4'd0,  1,  1'b0, ST_OK,       32'sd0, 5'd0},
			'{K_DELP,  32'sd0,          4'd0,  1,  1'b0, ST_OK,       32'sd0, 5'd0},
			'{K_POP,   32'sd0,          4'd0,  1,  1'b0, ST_OK,       32'sd0, 5'd0},
			'{K_NOP,   32'sh7fffffff,   4'd15, 1,  1'b1, ST_OK,       32'sd0, 5'd2},
			'{K_CLEAR, 32'sd0,          4'd0,  1,  1'b1, ST_OK,       32'sd0, 5'd0},
			'{K_PUSH,  32'sh7fffffff,   4'd0,  16, 1'b0, ST_OK,       32'sd0, 5'd0},
			'{K_PUSH,  32'sd1,          4'd0,  1,  1'b1, ST_FULL,     32'sd0, 5'd16},
			'{K_FIND,  32'sh7fffffff,   4'd0,  1,  1'b0, ST_OK,       32'sd0, 5'd0},
			'{K_READ,  32'sd0,          4'd15, 1,  1'b0, ST_OK,       32'sd0, 5'd0},
			'{K_DELP,  32'sd0,          4'd15, 1,  1'b0, ST_OK,       32'sd0, 5'd0},
			'{K_DELV,  32'sh7fffffff,   4'd0,  1,  1'b0, ST_OK,       32'sd0, 5'd0},
			'{K_CLEAR, 32'sd0,          4'd0,  1,  1'b1, ST_OK,       32'sd0, 5'd0}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			typed_res = '{status: dir_rows[r].t_status, value: dir_rows[r].t_value,
				pos: '0, count: dir_rows[r].t_count, last: 1'b1};
			repeat (dir_rows[r].reps)
				send_op(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].pos,
					dir_rows[r].typed, typed_res);
		end

		// phases of filling, mixed traffic and draining
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_OPS / 2) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			case ((n / 50) % 3)
			0: push_pct = 60;
			1: push_pct = 35;
			default: push_pct = 15;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				op = K_PUSH;
			else if (pick < push_pct + 2)
				op = K_CLEAR;
			else if (pick < push_pct + 4)
				op = K_NOP;
			else
				op = 3'($urandom_range(K_POP, K_READ));
			if ((op == K_DELV || op == K_FIND) && shadow_entries.size() != 0 &&
					$urandom_range(0, 9) < 7)
				val = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
			else if ($urandom_range(0, 7) == 0)
				val = $urandom;
			else
				val = value_pool[$urandom_range(0, 7)];
			if (shadow_entries.size() != 0 && $urandom_range(0, 3) != 0)
				pos = 4'($urandom_range(0, shadow_entries.size() - 1));
			else
				pos = 4'($urandom_range(0, 15));
			send_op(op, val, pos, 1'b0, typed_res);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("PASS searchable_fifo_queue");
		else
			$display("FAIL searchable_fifo_queue");
		$finish;
	end

endmodule
`default_nettype wire
